@@ design/vsfp_pkg.sv @@
// Shared types and constants for the vehicle status frame parser.
package vsfp_pkg;

    localparam int unsigned IDX_W     = 33;
    localparam int unsigned HDR_LEN   = 11;
    localparam int unsigned LEN_OFF   = 11;
    localparam int unsigned PAY_OFF   = 27;
    localparam int unsigned TAIL_LEN  = 2;
    localparam int unsigned SHORT_LEN = 132;
    localparam int unsigned LONG_LEN  = 216;
    localparam int unsigned SHORT_AT  = 27;
    localparam int unsigned LONG_AT   = 35;
    localparam logic [7:0]  CR_BYTE   = 8'h0D;
    localparam logic [7:0]  LF_BYTE   = 8'h0A;
    localparam int unsigned Q_DEPTH   = 2;
    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 56;

    localparam logic [7:0] HDR_BYTES [0:HDR_LEN-1] = '{
        8'h23, 8'h4D, 8'h6F, 8'h72, 8'h61, 8'h69, 8'h49, 8'h6E, 8'h66, 8'h6F, 8'h24
    };

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_HEADER    = 3'd1,
        ST_LAYOUT    = 3'd2,
        ST_TRUNCATED = 3'd3,
        ST_TAIL      = 3'd4,
        ST_SPEED     = 3'd5
    } status_t;

    // One classified byte on its way from the front to the back.
    typedef struct packed {
        logic [IDX_W-1:0] pos;
        logic [7:0]       data_byte;
        logic             frame_end;
        logic             hdr_ok;
    } item_t;

endpackage

@@ design/vsfp_front.sv @@
// Front end: accepts bytes, tracks frame position, checks header bytes.
module vsfp_front
    import vsfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       q_ready,
    output logic       in_ready,
    output logic       q_valid,
    output item_t      q_item
);

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             xfer;
    logic             hdr_ok;

    assign in_ready = q_ready;
    assign q_valid  = in_valid;
    assign xfer     = in_valid && q_ready;

    always_comb
    begin
        hdr_ok = 1'b1;
        if (idx_reg < IDX_W'(HDR_LEN))
        begin
            hdr_ok = (in_byte == HDR_BYTES[idx_reg[3:0]]);
        end
    end

    always_comb
    begin
        if (in_last)
            idx_next = '0;
        else if (idx_reg != {IDX_W{1'b1}})
            idx_next = idx_reg + IDX_W'(1);
        else
            idx_next = idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else if (xfer)
            idx_reg <= idx_next;
    end

    assign q_item.pos       = idx_reg;
    assign q_item.data_byte = in_byte;
    assign q_item.frame_end = in_last;
    assign q_item.hdr_ok    = hdr_ok;

endmodule

@@ design/vsfp_queue.sv @@
// Short register queue between front and back.
module vsfp_queue
    import vsfp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_valid,
    input  item_t wr_item,
    output logic  wr_ready,
    output logic  rd_valid,
    output item_t rd_item,
    input  logic  rd_ready
);

    localparam int unsigned PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

    item_t            mem [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign wr_ready = (count_reg != CNT_W'(Q_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = mem[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

@@ design/vsfp_back.sv @@
// Back end: assembles length and fields, checks tail, builds the result.
module vsfp_back
    import vsfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  item_t       q_item,
    output logic        q_ready,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status_code,
    output logic [7:0]  drive_mode,
    output logic [7:0]  gear,
    output logic [31:0] speed_bits
);

    logic             hm_reg,   hm_next;
    logic [31:0]      len_reg,  len_next;
    logic [7:0]       mode_reg, mode_next;
    logic [7:0]       gear_reg, gear_next;
    logic [31:0]      spd_reg,  spd_next;
    logic [1:0]       tail_reg, tail_next;

    logic             ov_reg;
    logic [2:0]       st_reg;
    logic [7:0]       om_reg;
    logic [7:0]       og_reg;
    logic [31:0]      os_reg;

    logic             pop;
    logic [IDX_W-1:0] pos;
    logic [7:0]       b;
    logic             near;
    logic [5:0]       lo;
    logic [5:0]       base;
    logic [5:0]       off;
    logic             cap_en;
    logic [1:0]       lsel;
    logic [1:0]       ssel;
    logic [IDX_W-1:0] tail_at;
    logic [IDX_W-1:0] tail_at1;
    status_t          code;

    assign q_ready = !q_item.frame_end || !ov_reg || out_ready;
    assign pop     = q_valid && q_ready;

    assign pos      = q_item.pos;
    assign b        = q_item.data_byte;
    assign near     = (pos[IDX_W-1:6] == '0);
    assign lo       = pos[5:0];
    assign tail_at  = IDX_W'(PAY_OFF) + {1'b0, len_reg};
    assign tail_at1 = IDX_W'(PAY_OFF + 1) + {1'b0, len_reg};
    assign lsel     = 2'(lo - 6'(LEN_OFF));
    assign off      = lo - base;
    assign ssel     = 2'(off - 6'd2);

    always_comb
    begin
        hm_next   = hm_reg;
        len_next  = len_reg;
        mode_next = mode_reg;
        gear_next = gear_reg;
        spd_next  = spd_reg;
        tail_next = tail_reg;
        cap_en    = 1'b0;
        base      = 6'(SHORT_AT);
        if (len_reg == 32'(SHORT_LEN))
        begin
            cap_en = 1'b1;
        end
        else if (len_reg >= 32'(LONG_LEN))
        begin
            cap_en = 1'b1;
            base   = 6'(LONG_AT);
        end

        if (pos < IDX_W'(HDR_LEN))
        begin
            hm_next = hm_reg && q_item.hdr_ok;
        end
        else if (pos < IDX_W'(LEN_OFF + 4))
        begin
            len_next[8*lsel +: 8] = b;
        end
        else
        begin
            if (cap_en && near)
            begin
                if (off == 6'd0)
                    mode_next = b;
                else if (off == 6'd1)
                    gear_next = b;
                else if (off >= 6'd2 && off <= 6'd5)
                    spd_next[8*ssel +: 8] = b;
            end
            if (pos == tail_at && b == CR_BYTE)
                tail_next[0] = 1'b1;
            if (pos == tail_at1 && b == LF_BYTE)
                tail_next[1] = 1'b1;
        end
    end

    // pos + 1 < limit is written as pos < limit - 1; saturation never passes.
    always_comb
    begin
        if (pos < IDX_W'(PAY_OFF + TAIL_LEN - 1) || !hm_next)
            code = ST_HEADER;
        else if (len_reg != 32'(SHORT_LEN) && len_reg < 32'(LONG_LEN))
            code = ST_LAYOUT;
        else if (pos < tail_at1)
            code = ST_TRUNCATED;
        else if (tail_next != 2'b11)
            code = ST_TAIL;
        else if (spd_next[30:23] == 8'hFF)
            code = ST_SPEED;
        else
            code = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hm_reg   <= 1'b1;
            len_reg  <= '0;
            mode_reg <= '0;
            gear_reg <= '0;
            spd_reg  <= '0;
            tail_reg <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                if (q_item.frame_end)
                begin
                    hm_reg   <= 1'b1;
                    len_reg  <= '0;
                    mode_reg <= '0;
                    gear_reg <= '0;
                    spd_reg  <= '0;
                    tail_reg <= '0;
                end
                else
                begin
                    hm_reg   <= hm_next;
                    len_reg  <= len_next;
                    mode_reg <= mode_next;
                    gear_reg <= gear_next;
                    spd_reg  <= spd_next;
                    tail_reg <= tail_next;
                end
            end
            if (pop && q_item.frame_end)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && q_item.frame_end)
        begin
            st_reg <= code;
            om_reg <= (code == ST_OK) ? mode_next : 8'd0;
            og_reg <= (code == ST_OK) ? gear_next : 8'd0;
            os_reg <= (code == ST_OK) ? spd_next  : 32'd0;
        end
    end

    assign out_valid    = ov_reg;
    assign status_code  = st_reg;
    assign drive_mode   = om_reg;
    assign gear         = og_reg;
    assign speed_bits   = os_reg;

endmodule

@@ design/vehicle_status_frame_parser_top.sv @@
// Top level of the vehicle status frame parser.
// Usage:
//   s_axis carries the frame one byte per transfer (tdata[7:0]); tlast marks
//   the last byte of the frame. m_axis carries exactly one result transfer
//   per frame, issued for the tlast byte: status code, drive mode, gear
//   and raw IEEE single speed bits (mode, gear and speed are zero on error).
//   Status codes: 0 ok, 1 header/short, 2 layout, 3 truncated, 4 tail, 5 speed not finite.
// Structure:
//   front (position counter, header compare) -> 2-entry queue -> back
//   (length assembly, field capture, CR LF check, result register).
// Throughput: one byte per cycle sustained unless a tlast byte waits on a held
//   result (see Stall); the position counter and the back-end update once per byte.
// Result path: with the queue empty, the tlast byte passes the queue register,
//   then the result register, before its result is valid on m_axis.
// Stall: while a result waits in the output register, the back keeps
//   consuming non-last bytes; only the next tlast byte waits, and the queue
//   then fills and deasserts s_axis_tready.
// Reset: rst_n (async, active low) clears frame state and empties the queue;
//   the next byte is byte 0 of a new frame. After each tlast the frame
//   state returns to its reset values as well.
module vehicle_status_frame_parser_top
    import vsfp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic                   s_axis_tlast,   // frame_end
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [2:0] status_code, [10:3] drive_mode,
                                                   // [18:11] gear, [50:19] speed_bits, rest 0
);

    item_t       f_item;
    logic        f_valid;
    logic        f_ready;
    item_t       b_item;
    logic        b_valid;
    logic        b_ready;
    logic [2:0]  status_code;
    logic [7:0]  drive_mode;
    logic [7:0]  gear;
    logic [31:0] speed_bits;

    vsfp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_byte  (s_axis_tdata[7:0]),
        .in_last  (s_axis_tlast),
        .q_ready  (f_ready),
        .in_ready (s_axis_tready),
        .q_valid  (f_valid),
        .q_item   (f_item)
    );

    vsfp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_item  (f_item),
        .wr_ready (f_ready),
        .rd_valid (b_valid),
        .rd_item  (b_item),
        .rd_ready (b_ready)
    );

    vsfp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (b_valid),
        .q_item       (b_item),
        .q_ready      (b_ready),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .status_code  (status_code),
        .drive_mode   (drive_mode),
        .gear         (gear),
        .speed_bits   (speed_bits)
    );

    assign m_axis_tdata = {5'd0, speed_bits, gear, drive_mode, status_code};

endmodule

@@ test/vsfp_frame_checker.sv @@
// Stream monitor for the vehicle status frame parser: predicts each frame's result and compares.
module vsfp_frame_checker
    import vsfp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic                   s_axis_tlast,   // frame_end
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [2:0] status_code, [10:3] drive_mode,
                                                   // [18:11] gear, [50:19] speed_bits
    output int                     mismatches,
    output int                     results_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t     code;
        logic [7:0]  mode;
        logic [7:0]  gear;
        logic [31:0] speed;
    } frame_result_t;

    // per-frame parse state
    logic [IDX_W-1:0] next_pos;
    logic             hdr_seen_ok;
    logic [31:0]      len_word;
    logic [7:0]       mode_cap;
    logic [7:0]       gear_cap;
    logic [31:0]      speed_cap;
    logic [1:0]       tail_seen;

    frame_result_t frame_results_q[$];

    initial mismatches = 0;

    task automatic clear_frame();
        next_pos    = '0;
        hdr_seen_ok = 1'b1;
        len_word    = '0;
        mode_cap    = '0;
        gear_cap    = '0;
        speed_cap   = '0;
        tail_seen   = '0;
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns  frame result %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic parse_frame_byte(input logic [7:0] b, input logic last);
        longint unsigned pos;
        longint unsigned base;
        longint unsigned tail_at;
        longint unsigned n;
        longint unsigned frame_size;
        logic            has_base;
        frame_result_t   r;
        pos = next_pos;
        if (pos < HDR_LEN)
        begin
            if (b != HDR_BYTES[pos])
                hdr_seen_ok = 1'b0;
        end
        else if (pos < LEN_OFF + 4)
        begin
            len_word[(pos - LEN_OFF) * 8 +: 8] = b;
        end
        else
        begin
            has_base = 1'b1;
            base     = 0;
            if (len_word == SHORT_LEN)
                base = SHORT_AT;
            else if (len_word >= LONG_LEN)
                base = LONG_AT;
            else
                has_base = 1'b0;
            if (has_base)
            begin
                if (pos == base)
                    mode_cap = b;
                else if (pos == base + 1)
                    gear_cap = b;
                else if (pos >= base + 2 && pos <= base + 5)
                    speed_cap[(pos - base - 2) * 8 +: 8] = b;
            end
            tail_at = 64'(PAY_OFF) + 64'(len_word);
            if (pos == tail_at && b == CR_BYTE)
                tail_seen[0] = 1'b1;
            if (pos == tail_at + 1 && b == LF_BYTE)
                tail_seen[1] = 1'b1;
        end
        // position counter sticks at all-ones
        if (next_pos != '1)
            next_pos = next_pos + 1'b1;

        if (last)
        begin
            n          = next_pos;
            frame_size = 64'(PAY_OFF) + 64'(len_word) + 64'(TAIL_LEN);
            r          = '0;
            if (n < PAY_OFF + TAIL_LEN || !hdr_seen_ok)
                r.code = ST_HEADER;
            else if (len_word != SHORT_LEN && len_word < LONG_LEN)
                r.code = ST_LAYOUT;
            else if (n < frame_size)
                r.code = ST_TRUNCATED;
            else if (tail_seen != 2'b11)
                r.code = ST_TAIL;
            else if (speed_cap[30:23] == 8'hFF)
                r.code = ST_SPEED;
            else
            begin
                r.code  = ST_OK;
                r.mode  = mode_cap;
                r.gear  = gear_cap;
                r.speed = speed_cap;
            end
            frame_results_q.push_back(r);
            clear_frame();
        end
    endtask

    task automatic check_frame_result(input logic [OUT_TDATA_W-1:0] word);
        frame_result_t want;
        if (frame_results_q.size() == 0)
        begin
            report_mismatch("with no frame outstanding", 64'(word), 64'd0);
            return;
        end
        want = frame_results_q.pop_front();
        if (word[2:0] != want.code)
            report_mismatch("status_code", 64'(word[2:0]), 64'(want.code));
        if (word[10:3] != want.mode)
            report_mismatch("drive_mode", 64'(word[10:3]), 64'(want.mode));
        if (word[18:11] != want.gear)
            report_mismatch("gear", 64'(word[18:11]), 64'(want.gear));
        if (word[50:19] != want.speed)
            report_mismatch("speed_bits", 64'(word[50:19]), 64'(want.speed));
        if (word[OUT_TDATA_W-1:51] != '0)
            report_mismatch("padding", 64'(word[OUT_TDATA_W-1:51]), 64'd0);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            clear_frame();
            frame_results_q.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_frame_result(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                parse_frame_byte(s_axis_tdata[7:0], s_axis_tlast);
        end
        results_pending = frame_results_q.size();
    end

endmodule

@@ test/tb_vehicle_status_frame_parser_top.sv @@
// Stimulus and verdict for the vehicle status frame parser testbench.
module tb_vehicle_status_frame_parser_top;
    timeunit 1ns;
    timeprecision 1ps;
    import vsfp_pkg::*;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [7:0] data_byte
    logic                   s_axis_tlast;   // frame_end
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [2:0] status_code, [10:3] drive_mode,
                                            // [18:11] gear, [50:19] speed_bits
    int                     mismatches;
    int                     results_pending;

    // Frame under construction; trailing bytes past the expected end are
    // ignored by the parser and are not counted as stimulus.
    logic [7:0] frame_buf[$];
    int         frame_trail;
    int         bytes_sent;
    int         frames_sent;

    // idling controls for the sender and receiver processes, set by the stimulus
    bit         tx_idle_on;
    bit         rx_idle_on;
    int         rx_hold_cycles;

    vehicle_status_frame_parser_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    vsfp_frame_checker u_frame_chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tlast    (s_axis_tlast),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .mismatches      (mismatches),
        .results_pending (results_pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop well past the slowest legal run.
    initial
    begin
        #10ms;
        $display("tb_vehicle_status_frame_parser_top: FAIL");
        $finish;
    end

    // Send one byte; an idle burst may come first. Valid is only dropped
    // at the start of a burst, so it never toggles within one time step.
    task automatic put_byte(input logic [7:0] b, input logic last);
        if (tx_idle_on && $urandom_range(0, 9) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic send_frame();
        foreach (frame_buf[i])
            put_byte(frame_buf[i], i == frame_buf.size() - 1);
        bytes_sent += frame_buf.size() - frame_trail;
        frames_sent++;
    endtask

    // Well-formed frame: header, length word, fields at the offset that the
    // length selects, random filler, CR LF at 27 + len, then trailing bytes.
    task automatic build_status_frame(input logic [31:0] len, input logic [7:0] mode,
                                      input logic [7:0] gear, input logic [31:0] speed,
                                      input int trail);
        longint unsigned base;
        longint unsigned tail_at;
        longint unsigned total;
        frame_buf.delete();
        for (int i = 0; i < HDR_LEN; i++)
            frame_buf.push_back(HDR_BYTES[i]);
        for (int k = 0; k < 4; k++)
            frame_buf.push_back(len[8*k +: 8]);
        base    = (len == SHORT_LEN) ? SHORT_AT : LONG_AT;
        tail_at = 64'(PAY_OFF) + 64'(len);
        total   = tail_at + TAIL_LEN + trail;
        for (longint unsigned i = LEN_OFF + 4; i < total; i++)
        begin
            if (i == tail_at)
                frame_buf.push_back(CR_BYTE);
            else if (i == tail_at + 1)
                frame_buf.push_back(LF_BYTE);
            else if (i == base)
                frame_buf.push_back(mode);
            else if (i == base + 1)
                frame_buf.push_back(gear);
            else if (i >= base + 2 && i <= base + 5)
                frame_buf.push_back(speed[(i - base - 2) * 8 +: 8]);
            else
                frame_buf.push_back(8'($urandom));
        end
        frame_trail = trail;
    endtask

    task automatic cut_frame(input int keep);
        while (frame_buf.size() > keep)
            void'(frame_buf.pop_back());
        frame_trail = 0;
    endtask

    // Short junk frame; half of them start with a correct header prefix.
    task automatic build_noise_frame(input int max_len);
        int n;
        int hdr_part;
        n = $urandom_range(1, max_len);
        hdr_part = ($urandom_range(0, 1) != 0) ? $urandom_range(0, HDR_LEN) : 0;
        frame_buf.delete();
        for (int i = 0; i < n; i++)
            frame_buf.push_back((i < hdr_part) ? HDR_BYTES[i] : 8'($urandom));
        frame_trail = 0;
    endtask

    task automatic build_random_frame();
        logic [31:0] len;
        logic [31:0] speed;
        int          kind;
        int          trail;
        int          tail_at;
        kind  = $urandom_range(0, 99);
        len   = ($urandom_range(0, 1) != 0) ? SHORT_LEN : LONG_LEN + $urandom_range(0, 24);
        speed = $urandom;
        if (speed[30:23] == 8'hFF)
            speed[23] = 1'b0;
        trail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (kind < 45)
        begin
            build_status_frame(len, 8'($urandom), 8'($urandom), speed, trail);
        end
        else if (kind < 53)
        begin
            // header corruption: one flipped bit
            build_status_frame(len, 8'($urandom), 8'($urandom), speed, trail);
            frame_buf[$urandom_range(0, HDR_LEN - 1)] ^= 8'(1 << $urandom_range(0, 7));
        end
        else if (kind < 61)
        begin
            len = $urandom_range(0, LONG_LEN - 1);
            if (len == SHORT_LEN)
                len = SHORT_LEN + 1;
            build_status_frame(len, 8'($urandom), 8'($urandom), speed, trail);
        end
        else if (kind < 70)
        begin
            build_status_frame(len, 8'($urandom), 8'($urandom), speed, 0);
            cut_frame($urandom_range(PAY_OFF + TAIL_LEN, frame_buf.size() - 1));
        end
        else if (kind < 79)
        begin
            // broken CR or LF
            build_status_frame(len, 8'($urandom), 8'($urandom), speed, trail);
            tail_at = PAY_OFF + len + $urandom_range(0, 1);
            frame_buf[tail_at] ^= 8'($urandom_range(1, 255));
        end
        else if (kind < 85)
        begin
            speed[30:23] = 8'hFF;
            build_status_frame(len, 8'($urandom), 8'($urandom), speed, trail);
        end
        else if (kind < 89)
        begin
            // huge length word: always short of the declared size
            build_status_frame(SHORT_LEN, 8'($urandom), 8'($urandom), speed, 0);
            len = $urandom | 32'h8000_0000;
            for (int k = 0; k < 4; k++)
                frame_buf[LEN_OFF + k] = len[8*k +: 8];
        end
        else
        begin
            build_noise_frame(40);
        end
    endtask

    // Receiver: random stalls, or one long hold when the stimulus asks.
    initial
    begin
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_hold_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge clk);
                rx_hold_cycles = 0;
            end
            else if (rx_idle_on && $urandom_range(0, 7) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        int waited;
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tlast   = 1'b0;
        tx_idle_on     = 1'b1;
        rx_idle_on     = 1'b1;
        rx_hold_cycles = 0;
        bytes_sent     = 0;
        frames_sent    = 0;
        frame_trail    = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames: field extremes, each status code, edge lengths.
        // Error frames whose code is decided early are cut short.
        build_status_frame(SHORT_LEN, 8'h80, 8'h7F, 32'h7F7F_FFFF, 0);
        send_frame();
        // bytes past the expected end are ignored
        build_status_frame(LONG_LEN + 1, 8'h7F, 8'h80, 32'hFF7F_FFFF, 5);
        send_frame();
        // infinity
        build_status_frame(SHORT_LEN, 8'h01, 8'h02, 32'h7F80_0000, 0);
        send_frame();
        // header mismatch at first and last header byte
        build_status_frame(SHORT_LEN, 8'h05, 8'h06, 32'h3F80_0000, 0);
        frame_buf[0] = 8'h22;
        cut_frame(40);
        send_frame();
        build_status_frame(SHORT_LEN, 8'h05, 8'h06, 32'h3F80_0000, 0);
        frame_buf[HDR_LEN - 1] ^= 8'h80;
        cut_frame(40);
        send_frame();
        // too short: one byte, and one byte under the minimum
        frame_buf.delete();
        frame_buf.push_back(HDR_BYTES[0]);
        frame_trail = 0;
        send_frame();
        build_status_frame(SHORT_LEN, 8'h07, 8'h08, 32'h4000_0000, 0);
        cut_frame(PAY_OFF + TAIL_LEN - 1);
        send_frame();
        // layout errors: zero length (minimum size frame), 131, 215
        build_status_frame(0, 8'h00, 8'h00, 32'h0, 0);
        send_frame();
        build_status_frame(SHORT_LEN - 1, 8'h09, 8'h0A, 32'h0, 0);
        cut_frame(40);
        send_frame();
        build_status_frame(LONG_LEN - 1, 8'h09, 8'h0A, 32'h0, 0);
        cut_frame(40);
        send_frame();
        // truncation: missing LF, and an all-ones length word
        build_status_frame(SHORT_LEN, 8'h0B, 8'h0C, 32'h0, 0);
        cut_frame(PAY_OFF + SHORT_LEN + 1);
        send_frame();
        build_status_frame(SHORT_LEN, 8'h0B, 8'h0C, 32'h0, 0);
        for (int k = 0; k < 4; k++)
            frame_buf[LEN_OFF + k] = 8'hFF;
        cut_frame(40);
        send_frame();
        // tail error: LF where CR belongs
        build_status_frame(SHORT_LEN, 8'h0D, 8'h0E, 32'h0, 0);
        frame_buf[PAY_OFF + SHORT_LEN] = LF_BYTE;
        send_frame();

        // Long receiver hold while short frames keep coming: the output
        // register and the queue fill up and the input must stall.
        rx_hold_cycles = 400;
        for (int i = 0; i < 12; i++)
        begin
            build_noise_frame(6);
            send_frame();
        end

        // Random frames with random content, fewer than half of them well-formed. Idling
        // switches on and off in stretches and stops for the final part.
        while (bytes_sent < 1400)
        begin
            if (bytes_sent >= 1150)
            begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            else if (frames_sent % 6 == 0)
            begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
            end
            build_random_frame();
            send_frame();
        end
        s_axis_tvalid <= 1'b0;

        // Drain: on an idle path a result passes the queue and result registers,
        // so a short tail after the last result is plenty.
        waited = 0;
        while (results_pending != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);
        if (mismatches == 0 && results_pending == 0)
            $display("tb_vehicle_status_frame_parser_top: PASS");
        else
            $display("tb_vehicle_status_frame_parser_top: FAIL");
        $finish;
    end

endmodule
